FILE: hw/rtl/sensor_line_centroid_tracker_defines.svh
// Assertion macros for the sensor line centroid tracker.
// Used by modules that assert; expects clock and reset in scope.
`ifndef SENSOR_LINE_CENTROID_TRACKER_DEFINES_SVH
`define SENSOR_LINE_CENTROID_TRACKER_DEFINES_SVH

// condition must hold on every rising clock edge outside reset
`define SLCT_ASSERT(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("slct assertion failed");

// antecedent implies consequent in the next cycle
`define SLCT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("slct assertion failed");

`endif

FILE: hw/rtl/slct_pkg.sv
// Package for the sensor line centroid tracker: constants, codes and
// the command/status structs between controller and datapath. No dependencies.
package slct_pkg;
   localparam int WINDOW_LENGTH = 8;
   localparam int NUM_CH        = 3;
   localparam int SAMPLE_W      = 10;
   localparam int PTR_W         = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int SUM_W         = $clog2(WINDOW_LENGTH * 1023 + 1);
   localparam int POS_W         = 11;
   localparam int DIVIDEND_W    = 20;
   localparam int DIVISOR_W     = 12;
   localparam int CNT_W         = $clog2(DIVIDEND_W + 1);
   localparam logic [9:0] SCALE = 10'd1000;
   localparam logic [SAMPLE_W-1:0] RAW_MAX = 10'd1023;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd512;

   localparam logic [1:0] KIND_TRACK = 2'd0;
   localparam logic [1:0] KIND_CAL   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // op 0..2 map channels, op 3 is the centroid
   localparam logic [1:0] OP_POS = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       update;
      logic       div_start;
      logic       write_v;
      logic       out_load;
      logic [1:0] op;
   } ctl_cmd_type;

   typedef struct packed {
      logic trivial;
      logic div_busy;
      logic div_done;
   } dp_sts_type;
endpackage

FILE: hw/rtl/slct_divider.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on slct_pkg for widths.
module slct_divider
   import slct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic                  busy,
   output logic                  done
);
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  trial;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      ge      = !trial[DIVISOR_W+1];
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;
endmodule

FILE: hw/rtl/slct_datapath.sv
// Datapath: rings, sums, calibration, scaled values, centroid and result register.
// Depends on slct_pkg and slct_divider.
module slct_datapath
   import slct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   output dp_sts_type          sts,
   input  logic                csr_valid,
   input  logic [SAMPLE_W-1:0] csr_wdata,
   input  logic [1:0]          req_kind,
   input  logic [SAMPLE_W-1:0] req_sample_ch0,
   input  logic [SAMPLE_W-1:0] req_sample_ch1,
   input  logic [SAMPLE_W-1:0] req_sample_ch2,
   output logic [POS_W-1:0]    rsp_line_position,
   output logic                rsp_line_detected,
   output logic [SAMPLE_W-1:0] rsp_average_ch0,
   output logic [SAMPLE_W-1:0] rsp_average_ch1,
   output logic [SAMPLE_W-1:0] rsp_average_ch2
);
   logic [SAMPLE_W-1:0] thr_ff;
   logic [1:0]          kind_ff;
   logic [SAMPLE_W-1:0] raw_ff [NUM_CH];
   logic [SAMPLE_W-1:0] ring_ff [NUM_CH][WINDOW_LENGTH];
   logic [PTR_W-1:0]    ptr_ff;
   logic [SUM_W-1:0]    sum_ff [NUM_CH];
   logic [SAMPLE_W-1:0] min_ff [NUM_CH];
   logic [SAMPLE_W-1:0] max_ff [NUM_CH];
   logic                cal_ff;
   logic                det_ff;
   logic [SAMPLE_W-1:0] v_ff [NUM_CH];
   logic [POS_W-1:0]    pos_ff;

   logic [SAMPLE_W-1:0] avg_w [NUM_CH];
   logic [SAMPLE_W-1:0] sel_avg, sel_lo, sel_hi, triv_v, mag;
   logic [SAMPLE_W:0]   num, span;
   logic [DIVISOR_W-1:0] den, divisor;
   logic [DIVISOR_W-1:0] diff;
   logic                neg;
   logic [DIVIDEND_W-1:0] dividend, quo;
   logic [SAMPLE_W-1:0] clamp_q;
   logic                div_busy, div_done;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         avg_w[c] = SAMPLE_W'(sum_ff[c] / WINDOW_LENGTH);
      end
      sel_avg = avg_w[0];
      sel_lo  = min_ff[0];
      sel_hi  = max_ff[0];
      unique case (cmd.op)
         2'd1: begin sel_avg = avg_w[1]; sel_lo = min_ff[1]; sel_hi = max_ff[1]; end
         2'd2: begin sel_avg = avg_w[2]; sel_lo = min_ff[2]; sel_hi = max_ff[2]; end
         default: ;
      endcase
      num  = {1'b0, sel_avg} - {1'b0, sel_lo};
      span = {1'b0, sel_hi} - {1'b0, sel_lo};
      den  = DIVISOR_W'(v_ff[0]) + DIVISOR_W'(v_ff[1]) + DIVISOR_W'(v_ff[2]);
      diff = DIVISOR_W'(v_ff[2]) - DIVISOR_W'(v_ff[0]);
      if (cmd.op == OP_POS) begin
         neg         = diff[DIVISOR_W-1];
         mag         = neg ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
         divisor     = den;
         sts.trivial = (den == '0) || (diff == '0);
         triv_v      = '0;
      end else begin
         neg         = 1'b0;
         mag         = num[SAMPLE_W] ? SAMPLE_W'(-num) : num[SAMPLE_W-1:0];
         divisor     = DIVISOR_W'(span[SAMPLE_W] ? SAMPLE_W'(-span) : span[SAMPLE_W-1:0]);
         // opposite signs give a quotient at or below zero, clamped to zero
         sts.trivial = !cal_ff || (span == '0) || (num == '0)
                       || (num[SAMPLE_W] != span[SAMPLE_W]);
         triv_v      = cal_ff ? '0 : sel_avg;
      end
      dividend     = DIVIDEND_W'(mag) * DIVIDEND_W'(SCALE);
      clamp_q      = (quo > DIVIDEND_W'(SCALE)) ? SCALE : quo[SAMPLE_W-1:0];
      sts.div_busy = div_busy;
      sts.div_done = div_done;
   end

   slct_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quo),
      .busy     (div_busy),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
         ptr_ff <= '0;
         cal_ff <= 1'b0;
         for (int c = 0; c < NUM_CH; c++) begin
            sum_ff[c] <= '0;
            min_ff[c] <= RAW_MAX;
            max_ff[c] <= '0;
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
               ring_ff[c][i] <= '0;
            end
         end
      end else begin
         if (csr_valid) begin
            thr_ff <= csr_wdata;
         end
         if (cmd.update) begin
            unique case (kind_ff)
               KIND_TRACK: begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     sum_ff[c] <= sum_ff[c] - SUM_W'(ring_ff[c][ptr_ff]) + SUM_W'(raw_ff[c]);
                     ring_ff[c][ptr_ff] <= raw_ff[c];
                  end
                  ptr_ff <= (ptr_ff == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr_ff + 1'b1;
               end
               KIND_CAL: begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     if (raw_ff[c] < min_ff[c]) min_ff[c] <= raw_ff[c];
                     if (raw_ff[c] > max_ff[c]) max_ff[c] <= raw_ff[c];
                  end
                  cal_ff <= 1'b1;
               end
               KIND_CLEAR: begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     min_ff[c] <= RAW_MAX;
                     max_ff[c] <= '0;
                  end
                  cal_ff <= 1'b0;
               end
               default: ;
            endcase
         end
      end
      if (cmd.capture) begin
         kind_ff   <= req_kind;
         raw_ff[0] <= req_sample_ch0;
         raw_ff[1] <= req_sample_ch1;
         raw_ff[2] <= req_sample_ch2;
      end
      if (cmd.update) begin
         det_ff <= ((kind_ff == KIND_TRACK) || (kind_ff == KIND_CAL))
                   && ((raw_ff[0] > thr_ff) || (raw_ff[1] > thr_ff) || (raw_ff[2] > thr_ff));
      end
      if (cmd.write_v) begin
         if (cmd.op == OP_POS) begin
            if (sts.trivial) pos_ff <= '0;
            else pos_ff <= neg ? POS_W'(-quo[POS_W-1:0]) : quo[POS_W-1:0];
         end else begin
            v_ff[cmd.op] <= sts.trivial ? triv_v : clamp_q;
         end
      end
      if (cmd.out_load) begin
         rsp_line_position <= pos_ff;
         rsp_line_detected <= det_ff;
         rsp_average_ch0   <= avg_w[0];
         rsp_average_ch1   <= avg_w[1];
         rsp_average_ch2   <= avg_w[2];
      end
   end
endmodule

FILE: hw/rtl/slct_controller.sv
// Controller: sequences update, the four steps (each a division or a trivial write) and the result register.
// Depends on slct_pkg and the assertion macro header.
`include "sensor_line_centroid_tracker_defines.svh"
module slct_controller
   import slct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD  = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   always_comb begin
      accept        = req_valid && (state_ff == S_IDLE);
      state_in      = state_ff;
      op_in         = op_ff;
      cmd           = '0;
      cmd.op        = op_ff;
      cmd.capture   = accept;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_UPD;
         S_UPD: begin
            cmd.update = 1'b1;
            op_in      = '0;
            state_in   = S_PREP;
         end
         S_PREP: begin
            if (sts.trivial) begin
               cmd.write_v = 1'b1;
               op_in       = op_ff + 1'b1;
               state_in    = (op_ff == OP_POS) ? S_DONE : S_PREP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.write_v = 1'b1;
               op_in       = op_ff + 1'b1;
               state_in    = (op_ff == OP_POS) ? S_DONE : S_PREP;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `SLCT_ASSERT(a_load_free, !cmd.out_load || !rsp_valid_ff || !rsp_stall)
   `SLCT_ASSERT(a_start_idle_div, !cmd.div_start || !sts.div_busy)
   `SLCT_ASSERT_NEXT(a_accept_update, accept, state_ff == S_UPD)
   `SLCT_ASSERT_NEXT(a_load_valid, cmd.out_load, rsp_valid_ff)
endmodule

FILE: hw/rtl/sensor_line_centroid_tracker.sv
// Top level of the sensor line centroid tracker.
// Depends on slct_pkg, slct_controller and slct_datapath.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  kind, sample_ch0..2
//   rsp_      out        rsp_valid/rsp_stall  line_position, line_detected, average_ch0..2
//   csr_      in         csr_valid/csr_ready  line_threshold (csr_wdata)
//
// One item at a time: accept, the update state, then four steps (three scaled
// channels and the centroid), each a direct write when trivial or else a division
// through the shared 20-step radix-2 divider, then the result register.
// Reset is synchronous; the ring, sums and calibration clear at once, no sweep.
// A stalled result holds in the output register while the next item is accepted.
module sensor_line_centroid_tracker
   import slct_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_kind,
   input  logic [SAMPLE_W-1:0] req_sample_ch0,
   input  logic [SAMPLE_W-1:0] req_sample_ch1,
   input  logic [SAMPLE_W-1:0] req_sample_ch2,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [POS_W-1:0]    rsp_line_position,
   output logic                rsp_line_detected,
   output logic [SAMPLE_W-1:0] rsp_average_ch0,
   output logic [SAMPLE_W-1:0] rsp_average_ch1,
   output logic [SAMPLE_W-1:0] rsp_average_ch2,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SAMPLE_W-1:0] csr_wdata
);
   ctl_cmd_type cmd;
   dp_sts_type  sts;

   assign csr_ready = 1'b1;

   slct_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   slct_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_valid         (csr_valid),
      .csr_wdata         (csr_wdata),
      .req_kind          (req_kind),
      .req_sample_ch0    (req_sample_ch0),
      .req_sample_ch1    (req_sample_ch1),
      .req_sample_ch2    (req_sample_ch2),
      .rsp_line_position (rsp_line_position),
      .rsp_line_detected (rsp_line_detected),
      .rsp_average_ch0   (rsp_average_ch0),
      .rsp_average_ch1   (rsp_average_ch1),
      .rsp_average_ch2   (rsp_average_ch2)
   );
endmodule

FILE: tb/sensor_line_centroid_tracker_tb.sv
// Self-checking testbench for sensor_line_centroid_tracker: random and directed
// track, calibration, clear and unused-kind transactions and threshold writes checked against an internal predictor.
// Depends on slct_pkg and the RTL of the tracker.
module sensor_line_centroid_tracker_tb;
   import slct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic                    det;
      logic [SAMPLE_W-1:0]     avg0;
      logic [SAMPLE_W-1:0]     avg1;
      logic [SAMPLE_W-1:0]     avg2;
   } centroid_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_kind = 0;
   logic [SAMPLE_W-1:0] req_sample_ch0 = 0, req_sample_ch1 = 0, req_sample_ch2 = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [POS_W-1:0] rsp_line_position;
   logic rsp_line_detected;
   logic [SAMPLE_W-1:0] rsp_average_ch0, rsp_average_ch1, rsp_average_ch2;
   logic csr_valid = 0;
   logic csr_ready;
   logic [SAMPLE_W-1:0] csr_wdata = 0;

   sensor_line_centroid_tracker uut (.*);

   // predictor state
   logic [SAMPLE_W-1:0] ring [NUM_CH][WINDOW_LENGTH];
   int unsigned ring_ptr;
   int unsigned chan_sum [NUM_CH];
   int unsigned chan_min [NUM_CH];
   int unsigned chan_max [NUM_CH];
   bit calibrated;
   int unsigned threshold;

   centroid_result_type expected_results[$];
   int errors = 0;
   longint cycles = 0;
   bit stall_calm = 0;

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint map_channel(int c, int unsigned avg);
      longint lo, hi, span, q;
      if (!calibrated) return avg;
      lo = chan_min[c];
      hi = chan_max[c];
      span = hi - lo;
      if (span == 0) return 0;
      q = (longint'(avg) - lo) * 1000 / span;
      if (q < 0) q = 0;
      if (q > 1000) q = 1000;
      return q;
   endfunction

   function automatic centroid_result_type predict_centroid(logic [1:0] kind,
         logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s1, logic [SAMPLE_W-1:0] s2);
      centroid_result_type r;
      int unsigned raw [NUM_CH];
      int unsigned avg [NUM_CH];
      longint v [NUM_CH];
      longint den, diff, mag, pos;
      raw[0] = s0; raw[1] = s1; raw[2] = s2;
      r.det = 0;
      case (kind)
         KIND_TRACK: begin
            for (int c = 0; c < NUM_CH; c++) begin
               chan_sum[c] = chan_sum[c] - ring[c][ring_ptr] + raw[c];
               ring[c][ring_ptr] = raw[c];
            end
            ring_ptr = (ring_ptr + 1) % WINDOW_LENGTH;
         end
         KIND_CAL: begin
            for (int c = 0; c < NUM_CH; c++) begin
               if (raw[c] < chan_min[c]) chan_min[c] = raw[c];
               if (raw[c] > chan_max[c]) chan_max[c] = raw[c];
            end
            calibrated = 1;
         end
         KIND_CLEAR: begin
            for (int c = 0; c < NUM_CH; c++) begin
               chan_min[c] = 1023;
               chan_max[c] = 0;
            end
            calibrated = 0;
         end
         default: ;
      endcase
      if (kind == KIND_TRACK || kind == KIND_CAL)
         for (int c = 0; c < NUM_CH; c++)
            if (raw[c] > threshold) r.det = 1;
      for (int c = 0; c < NUM_CH; c++) begin
         avg[c] = chan_sum[c] / WINDOW_LENGTH;
         v[c] = map_channel(c, avg[c]);
      end
      den = v[0] + v[1] + v[2];
      pos = 0;
      if (den != 0) begin
         diff = v[2] - v[0];
         mag = (diff < 0 ? -diff : diff) * 1000 / den;
         pos = diff < 0 ? -mag : mag;
      end
      r.pos = pos[POS_W-1:0];
      r.avg0 = avg[0][SAMPLE_W-1:0];
      r.avg1 = avg[1][SAMPLE_W-1:0];
      r.avg2 = avg[2][SAMPLE_W-1:0];
      return r;
   endfunction

   task automatic send_sample(logic [1:0] kind, logic [SAMPLE_W-1:0] s0,
         logic [SAMPLE_W-1:0] s1, logic [SAMPLE_W-1:0] s2);
      int g;
      g = gap_len();
      // valid was dropped at the last negedge; raise it no earlier than the next one
      repeat (g + 1) @(negedge clock);
      req_valid <= 1;
      req_kind <= kind;
      req_sample_ch0 <= s0;
      req_sample_ch1 <= s1;
      req_sample_ch2 <= s2;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(predict_centroid(kind, s0, s1, s2));
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic write_threshold(logic [SAMPLE_W-1:0] value);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_valid <= 1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      threshold = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // result checker
   always @(posedge clock) begin
      centroid_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result pos=%0d", $time, $signed(rsp_line_position));
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (exp_r.pos !== rsp_line_position) begin
               $display("%0t: line_position exp %0d got %0d", $time, exp_r.pos,
                        $signed(rsp_line_position));
               errors++;
            end
            if (exp_r.det !== rsp_line_detected) begin
               $display("%0t: line_detected exp %0d got %0d", $time, exp_r.det,
                        rsp_line_detected);
               errors++;
            end
            if (exp_r.avg0 !== rsp_average_ch0) begin
               $display("%0t: average_ch0 exp %0d got %0d", $time, exp_r.avg0,
                        rsp_average_ch0);
               errors++;
            end
            if (exp_r.avg1 !== rsp_average_ch1) begin
               $display("%0t: average_ch1 exp %0d got %0d", $time, exp_r.avg1,
                        rsp_average_ch1);
               errors++;
            end
            if (exp_r.avg2 !== rsp_average_ch2) begin
               $display("%0t: average_ch2 exp %0d got %0d", $time, exp_r.avg2,
                        rsp_average_ch2);
               errors++;
            end
         end
      end
   end

   // output stall bursts: mostly none or short, a few long
   always begin
      int g;
      @(negedge clock);
      g = stall_calm ? 0 : gap_len();
      rsp_stall <= (g != 0);
      repeat (g) @(negedge clock);
   end

   task automatic test_directed();
      send_sample(KIND_TRACK, 0, 0, 0);
      send_sample(KIND_TRACK, 1023, 1023, 1023);
      send_sample(KIND_TRACK, 1023, 0, 0);
      send_sample(KIND_TRACK, 0, 0, 1023);
      send_sample(KIND_TRACK, 512, 513, 511);
      send_sample(KIND_UNUSED, 1023, 1023, 1023);
      send_sample(KIND_CAL, 100, 100, 100);       // zero span
      send_sample(KIND_TRACK, 100, 100, 100);
      send_sample(KIND_CAL, 900, 600, 300);
      send_sample(KIND_TRACK, 1023, 0, 700);
      send_sample(KIND_CLEAR, 1023, 1023, 1023);
      for (int i = 0; i < 8; i++) send_sample(KIND_TRACK, 0, 0, 0);
      send_sample(KIND_CAL, 0, 1023, 0);
      send_sample(KIND_TRACK, 683, 341, 0);
      send_sample(KIND_CLEAR, 0, 0, 0);
   endtask

   task automatic test_threshold_extremes();
      write_threshold(0);
      send_sample(KIND_TRACK, 1, 0, 0);
      send_sample(KIND_CAL, 0, 0, 0);
      write_threshold(1023);
      send_sample(KIND_TRACK, 1023, 1023, 1023);
      write_threshold(10'h2AA);
      send_sample(KIND_TRACK, 10'h2AB, 0, 0);
   endtask

   task automatic test_random(int count);
      logic [1:0] k;
      int r;
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 199) write_threshold(SAMPLE_W'($urandom_range(0, 1023)));
         stall_calm = (i % 300) < 40;
         r = $urandom_range(0, 99);
         k = r < 70 ? KIND_TRACK : r < 88 ? KIND_CAL : r < 96 ? KIND_CLEAR : KIND_UNUSED;
         if (r < 30)
            send_sample(k, SAMPLE_W'($urandom_range(0, 1023)),
                        SAMPLE_W'($urandom_range(0, 1023)),
                        SAMPLE_W'($urandom_range(0, 1023)));
         else
            send_sample(k, SAMPLE_W'($urandom_range(200, 800) + $urandom_range(0, 100)),
                        SAMPLE_W'($urandom_range(0, 1023)),
                        SAMPLE_W'($urandom_range(100, 900)));
      end
      stall_calm = 0;
   endtask

   initial begin
      for (int c = 0; c < NUM_CH; c++) begin
         for (int i = 0; i < WINDOW_LENGTH; i++) ring[c][i] = 0;
         chan_sum[c] = 0;
         chan_min[c] = 1023;
         chan_max[c] = 0;
      end
      ring_ptr = 0;
      calibrated = 0;
      threshold = THRESHOLD_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed();
      test_threshold_extremes();
      test_random(930);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
